/* hw/rtl/uart_rb_pkg.sv */
// Shared constants, codes and control structs for the UART ring buffer block.
// No dependencies; every other file imports it.
package uart_rb_pkg;

   localparam int RING_DEPTH  = 64;
   localparam int MAX_BURST   = 16;
   localparam int PTR_W       = $clog2(RING_DEPTH);
   localparam int CNT_W       = $clog2(RING_DEPTH + 1);
   localparam int BURST_W     = $clog2(MAX_BURST + 1);
   localparam int CFG_W       = 5;
   localparam int BURST_RESET = 16;

   localparam logic [1:0] OP_PUT     = 2'd0;
   localparam logic [1:0] OP_GET     = 2'd1;
   localparam logic [1:0] OP_SERVICE = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TX_FULL  = 2'd1;
   localparam logic [1:0] ST_RX_EMPTY = 2'd2;
   localparam logic [1:0] ST_RX_DROP  = 2'd3;

   typedef struct packed {
      logic req_ready;
      logic get_emit;
      logic drain_issue;
      logic drain_emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       req_valid;
      logic [1:0] req_opcode;
      logic       drain_none;
      logic       slot_free;
      logic       rd_valid;
      logic       remain_zero;
   } ctrl_sts_type;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(RING_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

endpackage

/* hw/rtl/uart_rb_if.sv */
// Valid/ready channel interfaces: request, response and CSR write.
// Depends on uart_rb_pkg for the register width.
interface uart_rb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] data_byte;
   logic       line_tx_ready;
   logic       line_rx_valid;
   logic [7:0] line_rx_byte;
   modport source (output valid, opcode, data_byte, line_tx_ready, line_rx_valid,
                   line_rx_byte, input ready);
   modport sink   (input valid, opcode, data_byte, line_tx_ready, line_rx_valid,
                   line_rx_byte, output ready);
endinterface

interface uart_rb_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] read_byte;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       tx_irq_enabled;
   logic       last;
   modport source (output valid, status, read_byte, tx_valid, tx_byte, tx_irq_enabled,
                   last, input ready);
   modport sink   (input valid, status, read_byte, tx_valid, tx_byte, tx_irq_enabled,
                   last, output ready);
endinterface

interface uart_rb_csr_if;
   import uart_rb_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/uart_rb_ctrl.sv */
// Sequencing FSM: idle, get read-out, transmit drain.
// Depends on uart_rb_pkg command/status structs.
module uart_rb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  uart_rb_pkg::ctrl_sts_type sts,
   output uart_rb_pkg::ctrl_cmd_type cmd
);
   import uart_rb_pkg::*;

   typedef enum logic [2:0] {
      CS_IDLE  = 3'b001,
      CS_GET   = 3'b010,
      CS_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         CS_IDLE: begin
            cmd.req_ready = sts.slot_free;
            if (sts.req_valid && sts.slot_free) begin
               if (sts.req_opcode == OP_GET) begin
                  state_in = CS_GET;
               end else if (sts.req_opcode == OP_SERVICE && !sts.drain_none) begin
                  state_in = CS_DRAIN;
               end
            end
         end
         CS_GET: begin
            cmd.get_emit = sts.slot_free;
            if (sts.slot_free) begin
               state_in = CS_IDLE;
            end
         end
         CS_DRAIN: begin
            cmd.drain_emit  = sts.rd_valid && sts.slot_free;
            cmd.drain_issue = !sts.remain_zero && (!sts.rd_valid || cmd.drain_emit);
            if (cmd.drain_emit && sts.remain_zero) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/uart_rb_dp.sv */
// Datapath: both byte rings, pointers, counts, burst register, response register.
// Depends on uart_rb_pkg and the channel interfaces.
module uart_rb_dp (
   input  logic                      clock,
   input  logic                      reset,
   uart_rb_req_if.sink               req_chan,
   uart_rb_rsp_if.source             rsp_chan,
   uart_rb_csr_if.sink               csr_chan,
   input  uart_rb_pkg::ctrl_cmd_type cmd,
   output uart_rb_pkg::ctrl_sts_type sts
);
   import uart_rb_pkg::*;

   logic [7:0]         tx_mem_ff [RING_DEPTH];
   logic [7:0]         rx_mem_ff [RING_DEPTH];
   logic [PTR_W-1:0]   tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [PTR_W-1:0]   rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [CNT_W-1:0]   tx_count_ff, tx_count_in, rx_count_ff, rx_count_in;
   logic               irq_ff, irq_in;
   logic [CFG_W-1:0]   burst_ff, burst_in;
   logic [BURST_W-1:0] remain_ff, remain_in;
   logic [1:0]         st_ff, st_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [7:0]         tx_rd_ff, rx_rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [7:0]         rsp_read_ff, rsp_read_in;
   logic               rsp_txv_ff, rsp_txv_in;
   logic [7:0]         rsp_txb_ff, rsp_txb_in;
   logic               rsp_irq_ff, rsp_irq_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept, slot_free, tx_we, rx_we, get_read;
   logic [BURST_W-1:0] burst_eff, n_now;
   logic [CNT_W-1:0]   count_after;
   logic [1:0]         rx_st;

   assign accept    = cmd.req_ready && req_chan.valid;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      if (burst_ff == '0) begin
         burst_eff = BURST_W'(1);
      end else if (int'(burst_ff) > MAX_BURST) begin
         burst_eff = BURST_W'(MAX_BURST);
      end else begin
         burst_eff = BURST_W'(burst_ff);
      end
      if (!req_chan.line_tx_ready) begin
         n_now = '0;
      end else if (int'(tx_count_ff) < int'(burst_eff)) begin
         n_now = BURST_W'(tx_count_ff);
      end else begin
         n_now = burst_eff;
      end
      count_after = tx_count_ff - CNT_W'(n_now);
   end

   assign sts.req_valid   = req_chan.valid;
   assign sts.req_opcode  = req_chan.opcode;
   assign sts.drain_none  = (n_now == '0);
   assign sts.slot_free   = slot_free;
   assign sts.rd_valid    = rd_valid_ff;
   assign sts.remain_zero = (remain_ff == '0);

   assign tx_we    = accept && req_chan.opcode == OP_PUT
                     && tx_count_ff != CNT_W'(RING_DEPTH);
   assign rx_we    = accept && req_chan.opcode == OP_SERVICE && req_chan.line_rx_valid
                     && rx_count_ff != CNT_W'(RING_DEPTH);
   assign get_read = accept && req_chan.opcode == OP_GET && rx_count_ff != '0;
   assign rx_st    = (req_chan.line_rx_valid && rx_count_ff == CNT_W'(RING_DEPTH))
                     ? ST_RX_DROP : ST_OK;

   always_comb begin
      tx_head_in    = tx_head_ff;
      tx_tail_in    = tx_tail_ff;
      tx_count_in   = tx_count_ff;
      rx_head_in    = rx_head_ff;
      rx_tail_in    = rx_tail_ff;
      rx_count_in   = rx_count_ff;
      irq_in        = irq_ff;
      burst_in      = burst_ff;
      remain_in     = remain_ff;
      st_in         = st_ff;
      rd_valid_in   = rd_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_txv_in    = rsp_txv_ff;
      rsp_txb_in    = rsp_txb_ff;
      rsp_irq_in    = rsp_irq_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_chan.valid) begin
         burst_in = csr_chan.data;
      end

      if (tx_we) begin
         tx_tail_in  = ring_next(tx_tail_ff);
         tx_count_in = tx_count_ff + 1'b1;
         irq_in      = 1'b1;
      end
      if (rx_we) begin
         rx_tail_in  = ring_next(rx_tail_ff);
         rx_count_in = rx_count_ff + 1'b1;
      end
      if (get_read) begin
         rx_head_in  = ring_next(rx_head_ff);
         rx_count_in = rx_count_ff - 1'b1;
      end

      if (accept) begin
         case (req_chan.opcode)
            OP_PUT: begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = tx_we ? ST_OK : ST_TX_FULL;
               rsp_read_in   = '0;
               rsp_txv_in    = 1'b0;
               rsp_txb_in    = '0;
               rsp_irq_in    = irq_in;
               rsp_last_in   = 1'b1;
            end
            OP_GET: begin
               st_in = get_read ? ST_OK : ST_RX_EMPTY;
            end
            OP_SERVICE: begin
               tx_count_in = count_after;
               if (count_after == '0) begin
                  irq_in = 1'b0;
               end
               remain_in = n_now;
               st_in     = rx_st;
               if (n_now == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = rx_st;
                  rsp_read_in   = '0;
                  rsp_txv_in    = 1'b0;
                  rsp_txb_in    = '0;
                  rsp_irq_in    = irq_in;
                  rsp_last_in   = 1'b1;
               end
            end
            default: begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_read_in   = '0;
               rsp_txv_in    = 1'b0;
               rsp_txb_in    = '0;
               rsp_irq_in    = irq_ff;
               rsp_last_in   = 1'b1;
            end
         endcase
      end

      if (cmd.get_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = st_ff;
         rsp_read_in   = (st_ff == ST_OK) ? rx_rd_ff : 8'h00;
         rsp_txv_in    = 1'b0;
         rsp_txb_in    = '0;
         rsp_irq_in    = irq_ff;
         rsp_last_in   = 1'b1;
      end

      if (cmd.drain_emit) begin
         rd_valid_in   = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_status_in = (remain_ff == '0) ? st_ff : ST_OK;
         rsp_read_in   = '0;
         rsp_txv_in    = 1'b1;
         rsp_txb_in    = tx_rd_ff;
         rsp_irq_in    = irq_ff;
         rsp_last_in   = (remain_ff == '0);
      end
      if (cmd.drain_issue) begin
         rd_valid_in = 1'b1;
         remain_in   = remain_ff - 1'b1;
         tx_head_in  = ring_next(tx_head_ff);
      end
   end

   // ring storage, registered read ports
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem_ff[tx_tail_ff] <= req_chan.data_byte;
      end
      if (cmd.drain_issue) begin
         tx_rd_ff <= tx_mem_ff[tx_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem_ff[rx_tail_ff] <= req_chan.line_rx_byte;
      end
      if (get_read) begin
         rx_rd_ff <= rx_mem_ff[rx_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         tx_count_ff  <= '0;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         rx_count_ff  <= '0;
         irq_ff       <= 1'b0;
         burst_ff     <= CFG_W'(BURST_RESET);
         remain_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         tx_count_ff  <= tx_count_in;
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         rx_count_ff  <= rx_count_in;
         irq_ff       <= irq_in;
         burst_ff     <= burst_in;
         remain_ff    <= remain_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_txv_ff    <= rsp_txv_in;
      rsp_txb_ff    <= rsp_txb_in;
      rsp_irq_ff    <= rsp_irq_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_chan.ready          = cmd.req_ready;
   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.read_byte      = rsp_read_ff;
   assign rsp_chan.tx_valid       = rsp_txv_ff;
   assign rsp_chan.tx_byte        = rsp_txb_ff;
   assign rsp_chan.tx_irq_enabled = rsp_irq_ff;
   assign rsp_chan.last           = rsp_last_ff;

endmodule

/* hw/rtl/uart_tx_rx_ring_buffers.sv */
// Top level of the UART transmit/receive ring buffers: FSM plus datapath.
// Depends on uart_rb_pkg, uart_rb_if, uart_rb_ctrl and uart_rb_dp.
//
//   port      dir   beat
//   req_chan  in    opcode, data_byte, line_tx_ready, line_rx_valid, line_rx_byte
//   rsp_chan  out   status, read_byte, tx_valid, tx_byte, tx_irq_enabled, last
//   csr_chan  in    burst_limit write data
//
// Put, service without drain and unused opcodes: the response is registered from the accepted request.
// Get: the receive ring read is registered first, then the response.
// Service draining n bytes: one byte per cycle off the transmit ring read port while
// the response is not stalled. Rings come out of reset empty through their counts;
// no clear pass. A stalled response holds the block; csr writes are always taken.
module uart_tx_rx_ring_buffers (
   input logic           clock,
   input logic           reset,
   uart_rb_req_if.sink   req_chan,
   uart_rb_rsp_if.source rsp_chan,
   uart_rb_csr_if.sink   csr_chan
);
   import uart_rb_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   uart_rb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   uart_rb_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule

/* bench/uart_rb_ring_checker.sv */
// Checker for the UART ring buffer block: tracks both rings, predicts the
// response beats of every request beat and compares them in order.
// Depends on uart_rb_pkg and the channel interfaces in uart_rb_if.
module uart_rb_ring_checker (
   input  logic   clock,
   input  logic   reset,
   uart_rb_req_if req_mon,
   uart_rb_rsp_if rsp_mon,
   uart_rb_csr_if csr_mon,
   output int     error_count,
   output int     pending_count
);
   import uart_rb_pkg::*;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] read_byte;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       tx_irq_enabled;
      logic       last;
   } rsp_beat_type;

   rsp_beat_type     expected_beats[$];
   logic [7:0]       tx_ring [RING_DEPTH];
   logic [7:0]       rx_ring [RING_DEPTH];
   logic [PTR_W-1:0] tx_rd, tx_wr;
   logic [PTR_W-1:0] rx_rd, rx_wr;
   int               tx_fill, rx_fill;
   logic             irq_en;
   logic [CFG_W-1:0] burst_cfg;
   int               errors = 0;
   int               beat_no = 0;

   task automatic flag_error(input string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         flag_error($sformatf("beat %0d %s: expected 0x%0h, got 0x%0h",
                              beat_no, name, want, got));
      end
   endtask

   task automatic predict_item(input logic [1:0] op, input logic [7:0] data,
                               input logic txr, input logic rxv,
                               input logic [7:0] rxb);
      logic [7:0]   drained [$];
      int           n;
      int           limit;
      int           k;
      logic [1:0]   rx_st;
      rsp_beat_type b;
      n     = 0;
      rx_st = ST_OK;
      b     = '0;
      b.last = 1'b1;
      case (op)
         OP_PUT: begin
            if (tx_fill < RING_DEPTH) begin
               tx_ring[tx_wr] = data;
               tx_wr = ring_next(tx_wr);
               tx_fill++;
               irq_en = 1'b1;
            end else begin
               b.status = ST_TX_FULL;
            end
            b.tx_irq_enabled = irq_en;
            expected_beats.push_back(b);
         end
         OP_GET: begin
            if (rx_fill == 0) begin
               b.status = ST_RX_EMPTY;
            end else begin
               b.read_byte = rx_ring[rx_rd];
               rx_rd = ring_next(rx_rd);
               rx_fill--;
            end
            b.tx_irq_enabled = irq_en;
            expected_beats.push_back(b);
         end
         OP_SERVICE: begin
            limit = (burst_cfg == 0) ? 1 : ((burst_cfg > MAX_BURST) ? MAX_BURST : burst_cfg);
            if (txr) begin
               while (n < limit && tx_fill > 0) begin
                  drained.push_back(tx_ring[tx_rd]);
                  tx_rd = ring_next(tx_rd);
                  tx_fill--;
                  n++;
               end
            end
            if (tx_fill == 0) irq_en = 1'b0;
            if (rxv) begin
               if (rx_fill < RING_DEPTH) begin
                  rx_ring[rx_wr] = rxb;
                  rx_wr = ring_next(rx_wr);
                  rx_fill++;
               end else begin
                  rx_st = ST_RX_DROP;
               end
            end
            if (n == 0) begin
               b.status = rx_st;
               b.tx_irq_enabled = irq_en;
               expected_beats.push_back(b);
            end else begin
               for (k = 0; k < n; k++) begin
                  b = '0;
                  b.tx_valid = 1'b1;
                  b.tx_byte = drained[k];
                  b.tx_irq_enabled = irq_en;
                  b.last = (k == n - 1);
                  b.status = b.last ? rx_st : ST_OK;
                  expected_beats.push_back(b);
               end
            end
         end
         default: begin
            b.tx_irq_enabled = irq_en;
            expected_beats.push_back(b);
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         expected_beats.delete();
         tx_rd = '0;
         tx_wr = '0;
         tx_fill = 0;
         rx_rd = '0;
         rx_wr = '0;
         rx_fill = 0;
         irq_en = 1'b0;
         burst_cfg = CFG_W'(BURST_RESET);
      end else begin
         if (csr_mon.valid && csr_mon.ready) burst_cfg = csr_mon.data;
         if (req_mon.valid && req_mon.ready) begin
            predict_item(req_mon.opcode, req_mon.data_byte, req_mon.line_tx_ready,
                         req_mon.line_rx_valid, req_mon.line_rx_byte);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_beats.size() == 0) begin
               flag_error($sformatf("beat %0d arrived with nothing expected", beat_no));
            end else begin
               want = expected_beats.pop_front();
               check_field("status", 8'(want.status), 8'(rsp_mon.status));
               check_field("read_byte", want.read_byte, rsp_mon.read_byte);
               check_field("tx_valid", 8'(want.tx_valid), 8'(rsp_mon.tx_valid));
               check_field("tx_byte", want.tx_byte, rsp_mon.tx_byte);
               check_field("tx_irq_enabled", 8'(want.tx_irq_enabled),
                           8'(rsp_mon.tx_irq_enabled));
               check_field("last", 8'(want.last), 8'(rsp_mon.last));
            end
            beat_no++;
         end
      end
      pending_count <= expected_beats.size();
      error_count <= errors;
   end

endmodule

/* bench/tb_uart_tx_rx_ring_buffers.sv */
// Testbench top for uart_tx_rx_ring_buffers: clock, reset, request and csr
// stimulus, random response stalls, watchdog and verdict.
// Depends on uart_rb_pkg, uart_rb_if and uart_rb_ring_checker.
module tb_uart_tx_rx_ring_buffers;
   import uart_rb_pkg::*;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [1:0] opcode;
      logic [7:0] data_byte;
      logic       line_tx_ready;
      logic       line_rx_valid;
      logic [7:0] line_rx_byte;
   } line_item_type;

   localparam logic [1:0] OP_SPARE     = 2'd3;
   localparam int         STALL_LIMIT  = 2000;
   localparam int         DRAIN_CYCLES = MAX_BURST + 4;

   logic clock;
   logic reset;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   quiet_cycles = 0;
   int   errors;
   int   pending;

   uart_rb_req_if req_chan ();
   uart_rb_rsp_if rsp_chan ();
   uart_rb_csr_if csr_chan ();

   uart_tx_rx_ring_buffers u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   uart_rb_ring_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_mon       (csr_chan),
      .error_count   (errors),
      .pending_count (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic line_item_type mk(input logic [1:0] op, input logic [7:0] data,
                                        input logic txr, input logic rxv,
                                        input logic [7:0] rxb);
      line_item_type it;
      it.opcode = op;
      it.data_byte = data;
      it.line_tx_ready = txr;
      it.line_rx_valid = rxv;
      it.line_rx_byte = rxb;
      return it;
   endfunction

   function automatic line_item_type pick_item(input bit drain_heavy);
      line_item_type it;
      int            roll;
      it = mk(OP_PUT, 8'($urandom_range(255)), 1'($urandom_range(1)),
              1'($urandom_range(1)), 8'($urandom_range(255)));
      roll = $urandom_range(9);
      if (drain_heavy) begin
         if (roll < 4) begin
            it.opcode = OP_SERVICE;
            it.line_tx_ready = 1'b1;
         end else if (roll < 7) begin
            it.opcode = OP_GET;
         end else if (roll < 9) begin
            it.opcode = OP_PUT;
         end else begin
            it.opcode = OP_SPARE;
         end
      end else begin
         if (roll < 3) begin
            it.opcode = OP_PUT;
         end else if (roll < 6) begin
            it.opcode = OP_GET;
         end else if (roll < 9) begin
            it.opcode = OP_SERVICE;
         end else begin
            it.opcode = OP_SPARE;
         end
      end
      return it;
   endfunction

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         IDLE_SEND: begin
            send_idle_pct = 62;
            recv_stall_pct = 0;
         end
         IDLE_RECV: begin
            send_idle_pct = 0;
            recv_stall_pct = 62;
         end
         default: begin
            send_idle_pct = 26;
            recv_stall_pct = 26;
         end
      endcase
   endtask

   task automatic send_item(input line_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= it.opcode;
      req_chan.data_byte <= it.data_byte;
      req_chan.line_tx_ready <= it.line_tx_ready;
      req_chan.line_rx_valid <= it.line_rx_valid;
      req_chan.line_rx_byte <= it.line_rx_byte;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // stop sending and wait until every predicted beat has been seen
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_burst(input logic [CFG_W-1:0] value);
      settle();
      csr_chan.valid <= 1'b1;
      csr_chan.data <= value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      line_item_type script[$];
      int            i;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.opcode <= OP_PUT;
      req_chan.data_byte <= '0;
      req_chan.line_tx_ready <= 1'b0;
      req_chan.line_rx_valid <= 1'b0;
      req_chan.line_rx_byte <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty rings, field extremes, unused opcode, line not ready
      set_idling(IDLE_NONE);
      script.push_back(mk(OP_GET, 8'hFF, 1'b1, 1'b1, 8'hFF));
      script.push_back(mk(OP_SERVICE, 8'h00, 1'b1, 1'b0, 8'h00));
      script.push_back(mk(OP_PUT, 8'h00, 1'b0, 1'b0, 8'h00));
      script.push_back(mk(OP_PUT, 8'hFF, 1'b1, 1'b1, 8'hFF));
      script.push_back(mk(OP_PUT, 8'hA5, 1'b0, 1'b1, 8'h3C));
      script.push_back(mk(OP_SPARE, 8'hFF, 1'b1, 1'b1, 8'hFF));
      script.push_back(mk(OP_SERVICE, 8'h00, 1'b0, 1'b1, 8'h00));
      script.push_back(mk(OP_SERVICE, 8'hFF, 1'b0, 1'b1, 8'hFF));
      script.push_back(mk(OP_SERVICE, 8'h00, 1'b1, 1'b1, 8'h5A));
      script.push_back(mk(OP_GET, 8'h00, 1'b0, 1'b0, 8'h00));
      script.push_back(mk(OP_GET, 8'h00, 1'b0, 1'b0, 8'h00));
      script.push_back(mk(OP_GET, 8'h00, 1'b0, 1'b0, 8'h00));
      script.push_back(mk(OP_GET, 8'h00, 1'b0, 1'b0, 8'h00));
      script.push_back(mk(OP_SERVICE, 8'h00, 1'b0, 1'b0, 8'h00));
      for (i = 0; i < 6; i++) begin
         script.push_back(mk(OP_PUT, 8'(8'h11 * (i + 1)), 1'b0, 1'b0, 8'h00));
      end
      script.push_back(mk(OP_SERVICE, 8'h00, 1'b1, 1'b0, 8'h00));
      script.push_back(mk(OP_SPARE, 8'h00, 1'b0, 1'b0, 8'h00));
      foreach (script[j]) send_item(script[j]);

      write_burst(CFG_W'(1));
      set_idling(IDLE_SEND);
      repeat (10) send_item(pick_item(1'b0));

      // fill both rings past full; burst 0 drains single beats on the noise services
      write_burst(CFG_W'(0));
      set_idling(IDLE_BOTH);
      for (i = 0; i < 68; i++) begin
         send_item(mk(OP_PUT, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 8'($urandom_range(255))));
         send_item(mk(OP_SERVICE, 8'($urandom_range(255)), 1'b0, 1'b1,
                      8'($urandom_range(255))));
         if ($urandom_range(9) == 0) begin
            send_item(mk($urandom_range(1) ? OP_SPARE : OP_SERVICE,
                         8'($urandom_range(255)), 1'b1, 1'b0, 8'($urandom_range(255))));
         end
         if (i == 34) settle();
      end

      write_burst(CFG_W'(31));
      set_idling(IDLE_RECV);
      repeat (12) send_item(pick_item(1'b1));

      write_burst(CFG_W'($urandom_range(2, 15)));
      set_idling(IDLE_BOTH);
      repeat (12) send_item(pick_item(1'b1));

      write_burst(CFG_W'(16));
      set_idling(IDLE_SEND);
      repeat (10) send_item(pick_item(1'b0));

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
